/* rtl/core/pcfwrl_pkg.sv */
// Package for the per-client fixed-window rate limiter.
// Holds table sizing, register indexes, outcome codes and the beat types.
// No dependencies.
`default_nettype none

package pcfwrl_pkg;

  localparam int TABLE_ENTRIES = 1024;
  localparam int IDX_W         = $clog2(TABLE_ENTRIES);
  localparam int USED_W        = $clog2(TABLE_ENTRIES + 1);

  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 16;

  localparam logic [CFG_INDEX_W-1:0] REG_WINDOW_SECONDS = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_MAX_REQUESTS   = 2'd1;

  localparam logic [15:0] WINDOW_SECONDS_RESET = 16'd60;
  localparam logic [15:0] MAX_REQUESTS_RESET   = 16'd100;
  localparam logic [15:0] COUNT_MAX            = 16'hFFFF;

  typedef enum logic [1:0] {
    OUT_NEW       = 2'd0,
    OUT_RESTART   = 2'd1,
    OUT_COUNTED   = 2'd2,
    OUT_UNTRACKED = 2'd3
  } outcome_t;

  typedef struct packed {
    logic [31:0] peer_addr;
    logic [31:0] now_seconds;
  } req_t;

  typedef struct packed {
    logic     allowed;
    outcome_t outcome;
  } rsp_t;

  typedef struct packed {
    logic [15:0] count;
    logic [31:0] win_begin;
  } entry_t;

endpackage

`default_nettype wire

/* rtl/core/per_client_fixed_window_rate_limiter.sv */
// Top level of the per-client fixed-window rate limiter.
// Uses pcfwrl_pkg for sizing, codes and beat types; holds both table memories.
//
// One request is handled at a time. The address memory is scanned one entry per
// cycle through its single read port, so a request that matches entry k waits
// on a scan of entries 0 to k, and a request from an unknown client on a scan of
// all entries_used entries. Entries are added in order of first appearance and
// never removed; with the table full, unknown clients are allowed without
// tracking. The response register lets a finished beat wait while the next
// request is accepted.
`default_nettype none

module per_client_fixed_window_rate_limiter (
  input  wire                                 clk,
  input  wire                                 rst,
  input  wire                                 req_valid,
  output logic                                req_stall,
  input  wire  pcfwrl_pkg::req_t              req,
  output logic                                rsp_valid,
  input  wire                                 rsp_stall,
  output pcfwrl_pkg::rsp_t                    rsp,
  input  wire                                 cfg_we,
  input  wire  [pcfwrl_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  wire  [pcfwrl_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import pcfwrl_pkg::*;

  typedef enum logic [2:0] {
    IDLE,
    SCAN,
    HIT_WAIT,
    HIT_UPD,
    MISS
  } state_t;

  state_t state;

  logic [15:0]       window_seconds;
  logic [15:0]       max_requests;
  logic [USED_W-1:0] entries_used;

  req_t              cur;
  logic [USED_W-1:0] scan_idx;
  logic              cmp_valid;
  logic [IDX_W-1:0]  cmp_idx;
  logic [IDX_W-1:0]  hit_idx;

  logic [31:0] addr_mem [TABLE_ENTRIES];
  entry_t      data_mem [TABLE_ENTRIES];
  logic [31:0] addr_rdata;
  entry_t      data_rdata;

  logic        scan_more;
  logic        scan_hit;
  logic        rsp_free;
  logic        rsp_load;
  logic        table_full;
  logic [31:0] elapsed;
  logic        restart;
  logic [15:0] count_next;
  entry_t      hit_wdata;
  rsp_t        hit_rsp;
  rsp_t        miss_rsp;

  assign req_stall  = (state != IDLE);
  assign scan_more  = (scan_idx < entries_used);
  assign scan_hit   = cmp_valid && (addr_rdata == cur.peer_addr);
  assign rsp_free   = !rsp_valid || !rsp_stall;
  assign rsp_load   = rsp_free && ((state == HIT_UPD) || (state == MISS));
  assign table_full = (entries_used == USED_W'(TABLE_ENTRIES));

  always_comb begin
    elapsed    = cur.now_seconds - data_rdata.win_begin;
    restart    = (elapsed >= {16'd0, window_seconds});
    count_next = (data_rdata.count == COUNT_MAX) ? COUNT_MAX : data_rdata.count + 16'd1;
    if (restart) begin
      hit_wdata.count     = 16'd1;
      hit_wdata.win_begin = cur.now_seconds;
      hit_rsp.allowed     = 1'b1;
      hit_rsp.outcome     = OUT_RESTART;
    end else begin
      hit_wdata.count     = count_next;
      hit_wdata.win_begin = data_rdata.win_begin;
      hit_rsp.allowed     = !(count_next > max_requests);
      hit_rsp.outcome     = OUT_COUNTED;
    end
    miss_rsp.allowed = 1'b1;
    miss_rsp.outcome = table_full ? OUT_UNTRACKED : OUT_NEW;
  end

  always_ff @(posedge clk) begin
    addr_rdata <= addr_mem[scan_idx[IDX_W-1:0]];
    data_rdata <= data_mem[hit_idx];
    if (state == HIT_UPD && rsp_free) begin
      data_mem[hit_idx] <= hit_wdata;
    end
    if (state == MISS && rsp_free && !table_full) begin
      addr_mem[entries_used[IDX_W-1:0]]           <= cur.peer_addr;
      data_mem[entries_used[IDX_W-1:0]].count     <= 16'd1;
      data_mem[entries_used[IDX_W-1:0]].win_begin <= cur.now_seconds;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      window_seconds <= WINDOW_SECONDS_RESET;
      max_requests   <= MAX_REQUESTS_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_WINDOW_SECONDS: window_seconds <= cfg_data;
        REG_MAX_REQUESTS:   max_requests   <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= IDLE;
      entries_used <= '0;
      rsp_valid    <= 1'b0;
      cmp_valid    <= 1'b0;
      scan_idx     <= '0;
    end else begin
      if (rsp_load) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        IDLE: begin
          if (req_valid) begin
            cur       <= req;
            scan_idx  <= '0;
            cmp_valid <= 1'b0;
            state     <= SCAN;
          end
        end
        SCAN: begin
          if (scan_hit) begin
            hit_idx <= cmp_idx;
            state   <= HIT_WAIT;
          end else if (!cmp_valid && !scan_more) begin
            state <= MISS;
          end else begin
            cmp_valid <= scan_more;
            cmp_idx   <= scan_idx[IDX_W-1:0];
            scan_idx  <= scan_idx + USED_W'(1);
          end
        end
        HIT_WAIT: begin
          state <= HIT_UPD;
        end
        HIT_UPD: begin
          if (rsp_free) begin
            rsp   <= hit_rsp;
            state <= IDLE;
          end
        end
        MISS: begin
          if (rsp_free) begin
            rsp <= miss_rsp;
            if (!table_full) begin
              entries_used <= entries_used + USED_W'(1);
            end
            state <= IDLE;
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire
